// ===== rtl/tcsni_pkg.sv =====
// Package for the TLS ClientHello server-name extractor.
// Shared byte and position types, protocol constants and the saturating and wide position adds.
// No dependencies.
`default_nettype none

package tcsni_pkg;

    localparam int POSITION_BITS = 18;

    typedef logic [7:0]               t_byte;
    typedef logic [15:0]              t_len;
    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [POSITION_BITS:0]   t_pos_wide;

    // Record and handshake type codes
    localparam t_byte REC_TYPE_HANDSHAKE = 8'h16;
    localparam t_byte HS_TYPE_CLIENT_HELLO = 8'h01;
    // Extension and name-entry type codes
    localparam t_len  EXT_TYPE_SERVER_NAME = 16'h0000;
    localparam t_byte NAME_TYPE_HOST = 8'h00;

    // Byte positions inside the fixed prefix
    localparam int REC_TYPE_POS = 0;
    localparam int HS_TYPE_POS = 5;
    // record header (5) + handshake header (4) + version and random (34), last index
    localparam int PREFIX_LAST_POS = 5 + 4 + 34 - 1;

    // a + b, saturated at the largest position
    function automatic t_pos pos_add(t_pos a, t_len b);
        t_pos_wide s;
        s = {1'b0, a} + t_pos_wide'(b);
        return s[POSITION_BITS] ? '1 : s[POSITION_BITS-1:0];
    endfunction

    // a + b without saturation, one bit wider
    function automatic t_pos_wide pos_add_wide(t_pos a, t_len b);
        return {1'b0, a} + t_pos_wide'(b);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tcsni_if.sv =====
// Stream interfaces of the extractor: input bytes and result beats.
// Depends on tcsni_pkg.
`default_nettype none

interface tcsni_in_if
    import tcsni_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface tcsni_out_if
    import tcsni_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte name_byte;
    logic  name_valid;
    logic  verdict;
    logic  found;

    modport source (output valid, output name_byte, output name_valid,
                    output verdict, output found, input ready);
    modport sink   (input valid, input name_byte, input name_valid,
                    input verdict, input found, output ready);
endinterface

`default_nettype wire

// ===== rtl/tls_client_hello_sni_extract.sv =====
// Top level of the TLS ClientHello server-name extractor.
// Uses tcsni_pkg and the stream interfaces in tcsni_if.sv.
//
// Takes one TLS record byte per beat, with end_of_packet on the packet's last
// byte. The record must be a handshake record carrying a ClientHello; the
// prefix, session id, cipher suites and compression methods are skipped by
// their length prefixes, then the extensions are walked. Bytes of the first
// host_name entry of a server_name extension come out as tentative name beats
// (name_valid=1). Every packet ends with exactly one verdict beat (verdict=1):
// found=1 only on the byte that closes the server_name extension when the name
// was non-empty and fit; found=0 on a wrong record or handshake type, an empty
// host name, any bounds failure or at packet end. Bytes after the verdict are
// ignored until end_of_packet, which returns all parse state to reset.
// Positions saturate at 2**POSITION_BITS-1. Rate: one input byte per clock.
// Each byte is parsed in the cycle it is accepted and its results (zero, one
// or two beats) go into a four-entry result queue, visible from the next cycle.
// Input ready is high while the queue holds at most two beats, so a byte that
// yields both a name beat and a verdict beat leaves an extra beat queued; with
// a sink that takes a beat every cycle the input never stalls otherwise.
`default_nettype none

module tls_client_hello_sni_extract
    import tcsni_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tcsni_in_if.sink     i_in,
    tcsni_out_if.source  o_out
);

    typedef enum logic [3:0] {
        PH_PREFIX,
        PH_SID_LEN,
        PH_SKIP_SID,
        PH_CS_LEN,
        PH_SKIP_CS,
        PH_CM_LEN,
        PH_SKIP_CM,
        PH_EXTS_LEN,
        PH_EXT_TYPE,
        PH_EXT_LEN_SNI,
        PH_EXT_LEN_OTHER,
        PH_SKIP_EXT,
        PH_LIST_LEN,
        PH_ENTRY_HDR,
        PH_NAME,
        PH_SKIP_ENTRY
    } t_phase;

    // Follow-up work after a field ends; resolved in order entry -> rest of ext -> ext
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_EXT_BND,
        ACT_SKIP_REST,
        ACT_ENTRY_BND
    } t_act;

    typedef struct packed {
        t_byte name_byte;
        logic  name_valid;
        logic  verdict;
        logic  found;
    } t_result;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // ---------------- parse state ----------------
    t_phase r_phase, n_phase;
    t_pos   r_position, n_position;
    t_len   r_field_remaining, n_field_remaining;
    t_len   r_length_accum, n_length_accum;
    t_pos   r_extensions_end, n_extensions_end;
    t_pos   r_sni_extension_end, n_sni_extension_end;
    t_pos   r_sni_list_end, n_sni_list_end;
    t_len   r_name_remaining, n_name_remaining;
    logic   r_verdict_sent, n_verdict_sent;

    // ---------------- result queue ----------------
    t_result             r_queue [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    logic     in_beat;
    logic     out_beat;
    logic     push_name;
    logic     push_verdict;
    logic     verdict_found;
    t_result  res_name;
    t_result  res_verdict;

    assign i_in.ready = (r_count <= QCNT_W'(QDEPTH - 2));
    assign in_beat    = i_in.valid && i_in.ready;
    assign out_beat   = o_out.valid && o_out.ready;

    // ---------------- one parse step per accepted byte ----------------
    always_comb begin
        t_byte b;
        t_pos  nx;
        t_len  acc_new;
        t_len  fr_dec;
        logic  len_done;
        t_act  act;

        b        = i_in.data_byte;
        nx       = pos_add(r_position, 16'd1);
        acc_new  = {r_length_accum[7:0], b};
        fr_dec   = r_field_remaining - 16'd1;
        len_done = (fr_dec == 16'd0);
        act      = ACT_NONE;

        n_phase             = r_phase;
        n_position          = r_position;
        n_field_remaining   = r_field_remaining;
        n_length_accum      = r_length_accum;
        n_extensions_end    = r_extensions_end;
        n_sni_extension_end = r_sni_extension_end;
        n_sni_list_end      = r_sni_list_end;
        n_name_remaining    = r_name_remaining;
        n_verdict_sent      = r_verdict_sent;
        push_name           = 1'b0;
        push_verdict        = 1'b0;
        verdict_found       = 1'b0;

        if (!r_verdict_sent) begin
            unique case (r_phase)
                PH_PREFIX: begin
                    if ((r_position == t_pos'(REC_TYPE_POS) && b != REC_TYPE_HANDSHAKE) ||
                        (r_position == t_pos'(HS_TYPE_POS) && b != HS_TYPE_CLIENT_HELLO)) begin
                        push_verdict   = 1'b1;
                        n_verdict_sent = 1'b1;
                    end else if (r_position >= t_pos'(PREFIX_LAST_POS)) begin
                        n_phase = PH_SID_LEN;
                    end
                end
                PH_SID_LEN, PH_CM_LEN: begin
                    n_field_remaining = {8'd0, b};
                    if (b == 8'd0) begin
                        n_phase           = (r_phase == PH_SID_LEN) ? PH_CS_LEN : PH_EXTS_LEN;
                        n_field_remaining = 16'd2;
                        n_length_accum    = 16'd0;
                    end else begin
                        n_phase = (r_phase == PH_SID_LEN) ? PH_SKIP_SID : PH_SKIP_CM;
                    end
                end
                PH_SKIP_SID, PH_SKIP_CS, PH_SKIP_CM: begin
                    n_field_remaining = fr_dec;
                    if (len_done) begin
                        if (r_phase == PH_SKIP_CS) begin
                            n_phase = PH_CM_LEN;
                        end else begin
                            n_phase           = (r_phase == PH_SKIP_SID) ? PH_CS_LEN : PH_EXTS_LEN;
                            n_field_remaining = 16'd2;
                            n_length_accum    = 16'd0;
                        end
                    end
                end
                PH_CS_LEN: begin
                    n_length_accum    = acc_new;
                    n_field_remaining = fr_dec;
                    if (len_done) begin
                        n_field_remaining = acc_new;
                        n_phase           = (acc_new == 16'd0) ? PH_CM_LEN : PH_SKIP_CS;
                    end
                end
                PH_EXTS_LEN: begin
                    n_length_accum    = acc_new;
                    n_field_remaining = fr_dec;
                    if (len_done) begin
                        n_extensions_end = pos_add(nx, acc_new);
                        act              = ACT_EXT_BND;
                    end
                end
                PH_EXT_TYPE: begin
                    n_length_accum    = acc_new;
                    n_field_remaining = fr_dec;
                    if (len_done) begin
                        n_phase = (acc_new == EXT_TYPE_SERVER_NAME) ? PH_EXT_LEN_SNI
                                                                    : PH_EXT_LEN_OTHER;
                        n_field_remaining = 16'd2;
                        n_length_accum    = 16'd0;
                    end
                end
                PH_EXT_LEN_SNI, PH_EXT_LEN_OTHER: begin
                    n_length_accum    = acc_new;
                    n_field_remaining = fr_dec;
                    if (len_done) begin
                        n_sni_extension_end = pos_add(nx, acc_new);
                        if (n_sni_extension_end > r_extensions_end ||
                            (r_phase == PH_EXT_LEN_SNI &&
                             pos_add_wide(nx, 16'd2) > {1'b0, r_extensions_end})) begin
                            push_verdict   = 1'b1;
                            n_verdict_sent = 1'b1;
                        end else if (r_phase == PH_EXT_LEN_SNI && acc_new >= 16'd2) begin
                            n_phase           = PH_LIST_LEN;
                            n_field_remaining = 16'd2;
                            n_length_accum    = 16'd0;
                        end else begin
                            act = ACT_SKIP_REST;
                        end
                    end
                end
                PH_SKIP_EXT: begin
                    if (nx >= r_sni_extension_end) begin
                        act = ACT_EXT_BND;
                    end
                end
                PH_LIST_LEN: begin
                    n_length_accum    = acc_new;
                    n_field_remaining = fr_dec;
                    if (len_done) begin
                        n_sni_list_end = pos_add(nx, acc_new);
                        if (n_sni_list_end > r_sni_extension_end) begin
                            n_sni_list_end = r_sni_extension_end;
                        end
                        act = ACT_ENTRY_BND;
                    end
                end
                PH_ENTRY_HDR: begin
                    if (r_field_remaining == 16'd3) begin
                        // entry type byte, held until the entry length is in
                        n_name_remaining  = {8'd0, b};
                        n_field_remaining = 16'd2;
                    end else begin
                        n_length_accum    = acc_new;
                        n_field_remaining = fr_dec;
                        if (len_done) begin
                            if (pos_add_wide(nx, acc_new) > {1'b0, r_sni_list_end}) begin
                                act = ACT_SKIP_REST;
                            end else if (r_name_remaining == {8'd0, NAME_TYPE_HOST}) begin
                                if (acc_new == 16'd0) begin
                                    push_verdict   = 1'b1;
                                    n_verdict_sent = 1'b1;
                                end else begin
                                    n_name_remaining = acc_new;
                                    n_phase          = PH_NAME;
                                end
                            end else if (acc_new == 16'd0) begin
                                act = ACT_ENTRY_BND;
                            end else begin
                                n_field_remaining = acc_new;
                                n_phase           = PH_SKIP_ENTRY;
                            end
                        end
                    end
                end
                PH_NAME: begin
                    if (r_name_remaining != 16'd0) begin
                        push_name        = 1'b1;
                        n_name_remaining = r_name_remaining - 16'd1;
                    end
                    if (nx >= r_sni_extension_end) begin
                        push_verdict   = 1'b1;
                        verdict_found  = 1'b1;
                        n_verdict_sent = 1'b1;
                    end
                end
                PH_SKIP_ENTRY: begin
                    n_field_remaining = fr_dec;
                    if (len_done) begin
                        act = ACT_ENTRY_BND;
                    end
                end
            endcase

            // Boundary resolution, next-value ends already in place
            if (act == ACT_ENTRY_BND) begin
                if (pos_add_wide(nx, 16'd3) > {1'b0, n_sni_list_end}) begin
                    act = ACT_SKIP_REST;
                end else begin
                    n_phase           = PH_ENTRY_HDR;
                    n_field_remaining = 16'd3;
                    n_length_accum    = 16'd0;
                end
            end
            if (act == ACT_SKIP_REST) begin
                if (nx >= n_sni_extension_end) begin
                    act = ACT_EXT_BND;
                end else begin
                    n_phase = PH_SKIP_EXT;
                end
            end
            if (act == ACT_EXT_BND) begin
                if (pos_add_wide(nx, 16'd4) > {1'b0, n_extensions_end}) begin
                    push_verdict   = 1'b1;
                    n_verdict_sent = 1'b1;
                end else begin
                    n_phase           = PH_EXT_TYPE;
                    n_field_remaining = 16'd2;
                    n_length_accum    = 16'd0;
                end
            end

            n_position = nx;
        end

        // Packet end: late not-found verdict if needed, then back to reset state
        if (i_in.end_of_packet) begin
            if (!n_verdict_sent) begin
                push_verdict  = 1'b1;
                verdict_found = 1'b0;
            end
            n_phase             = PH_PREFIX;
            n_position          = '0;
            n_field_remaining   = '0;
            n_length_accum      = '0;
            n_extensions_end    = '0;
            n_sni_extension_end = '0;
            n_sni_list_end      = '0;
            n_name_remaining    = '0;
            n_verdict_sent      = 1'b0;
        end
    end

    assign res_name    = '{name_byte: i_in.data_byte, name_valid: 1'b1,
                           verdict: 1'b0, found: 1'b0};
    assign res_verdict = '{name_byte: 8'd0, name_valid: 1'b0,
                           verdict: 1'b1, found: verdict_found};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase             <= PH_PREFIX;
            r_position          <= '0;
            r_field_remaining   <= '0;
            r_length_accum      <= '0;
            r_extensions_end    <= '0;
            r_sni_extension_end <= '0;
            r_sni_list_end      <= '0;
            r_name_remaining    <= '0;
            r_verdict_sent      <= 1'b0;
        end else if (in_beat) begin
            r_phase             <= n_phase;
            r_position          <= n_position;
            r_field_remaining   <= n_field_remaining;
            r_length_accum      <= n_length_accum;
            r_extensions_end    <= n_extensions_end;
            r_sni_extension_end <= n_sni_extension_end;
            r_sni_list_end      <= n_sni_list_end;
            r_name_remaining    <= n_name_remaining;
            r_verdict_sent      <= n_verdict_sent;
        end
    end

    // ---------------- result queue ----------------
    // Name beat goes ahead of the verdict beat of the same byte.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            if (push_name) begin
                r_queue[r_wr_ptr] <= res_name;
                if (push_verdict) begin
                    r_queue[r_wr_ptr + QPTR_W'(1)] <= res_verdict;
                end
            end else if (push_verdict) begin
                r_queue[r_wr_ptr] <= res_verdict;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [QCNT_W-1:0] pushes;
        pushes = in_beat ? (QCNT_W'(push_name) + QCNT_W'(push_verdict)) : '0;
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + pushes[QPTR_W-1:0];
            if (out_beat) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + pushes - QCNT_W'(out_beat);
        end
    end

    assign o_out.valid      = (r_count != '0);
    assign o_out.name_byte  = r_queue[r_rd_ptr].name_byte;
    assign o_out.name_valid = r_queue[r_rd_ptr].name_valid;
    assign o_out.verdict    = r_queue[r_rd_ptr].verdict;
    assign o_out.found      = r_queue[r_rd_ptr].found;

endmodule

`default_nettype wire

// ===== rtl/tcsni_checker.sv =====
// Port-level checks for tls_client_hello_sni_extract, with its bind.
// Depends on tcsni_pkg; attached to the top level by the bind below.
`default_nettype none

module tcsni_checker
    import tcsni_pkg::*;
(
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire t_byte i_name_byte,
    input wire logic  i_name_valid,
    input wire logic  i_verdict,
    input wire logic  i_found
);

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_name_byte) && $stable(i_name_valid) &&
            $stable(i_verdict) && $stable(i_found))
        else $error("result payload changed while stalled");

    // A beat is either a name byte or a verdict, never both nor neither
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot({i_name_valid, i_verdict}))
        else $error("result beat is not exactly one of name or verdict");

    // found only rides on a verdict
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> i_verdict)
        else $error("found set on a name beat");

    // A verdict beat carries no name byte
    a_verdict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict |-> i_name_byte == 8'd0)
        else $error("verdict beat carries a name byte");

endmodule

bind tls_client_hello_sni_extract tcsni_checker u_tcsni_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_name_byte  (o_out.name_byte),
    .i_name_valid (o_out.name_valid),
    .i_verdict    (o_out.verdict),
    .i_found      (o_out.found)
);

`default_nettype wire
